FILE: src/pbfa_pkg.sv
// pbfa_pkg: field widths, register indexes and reset values for the packed
// bit field array core. Depends on nothing; used by packed_bit_field_array_core.
package pbfa_pkg;

  localparam int unsigned IdxW      = 13;  // item index
  localparam int unsigned ValW      = 32;  // item value
  localparam int unsigned ItemWW    = 6;   // item_width register
  localparam int unsigned CapW      = 14;  // capacity_bits register
  localparam int unsigned CfgDataW  = 14;  // widest register
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned StartW    = 19;  // linear bit address, start plus width
  localparam int unsigned CmpW      = 20;  // wide enough for the memory size in bits
  localparam int unsigned MaxWidth  = 32;

  localparam int unsigned MemBytesDefault = 1024;

  localparam logic [CfgIdxW-1:0] CfgItemWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCapacity  = 2'd1;

  localparam logic [ItemWW-1:0] ItemWidthRst = 6'd8;
  localparam logic [CapW-1:0]   CapacityRst  = 14'd8192;

  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

endpackage

FILE: src/pbfa_ram.sv
// pbfa_ram: generic single-port RAM with registered read data.
// No dependencies; used by packed_bit_field_array_core for the byte store.
module pbfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/packed_bit_field_array_core.sv
// packed_bit_field_array_core: top level, byte-wide sequencer over a packed
// bit field store. Depends on pbfa_pkg and pbfa_ram.
//
// Usage: each request on the in channel (valid/ready) reads or writes one item
// of item_width bits, packed back to back in a byte RAM of MEM_BYTES bytes.
// Every request gives exactly one response on the out channel (valid/ready):
// read_value, out_of_range and truncated. Registers item_width and
// capacity_bits must be set through the plain write port only while no
// request is open; the block itself does not enforce this.
// Timing: a request steps through StCalc (form the start bit) and StChk (check
// range), then StRd and StMod for each byte covered (read, then modify and
// write back through the single RAM port), then StDone, which loads the
// response register; an out of range request goes from StChk to StDone. An
// item covers 1 to 5 bytes, and in_ready_o rises again in the same cycle that
// the response becomes valid.
//
// Reset clears the sequencer and the response valid flag, sets the registers
// to width 8 and capacity 8192; RAM contents are undefined until written. A
// stalled receiver holds the response; a following request still runs and
// waits in its last step until the response register is free.
module packed_bit_field_array_core #(
  parameter int unsigned MEM_BYTES = pbfa_pkg::MemBytesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pbfa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pbfa_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [pbfa_pkg::IdxW-1:0]       item_index_i,
  input  logic [pbfa_pkg::ValW-1:0]       write_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pbfa_pkg::ValW-1:0]       read_value_o,
  output logic                            out_of_range_o,
  output logic                            truncated_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [pbfa_pkg::CmpW-1:0] MemBits = pbfa_pkg::CmpW'(MEM_BYTES * 8);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StCalc = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StRd   = 3'd3;
  localparam logic [2:0] StMod  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  // configuration
  logic [pbfa_pkg::ItemWW-1:0] width_q;
  logic [pbfa_pkg::CapW-1:0]   cap_q;
  logic [pbfa_pkg::ItemWW-1:0] w;
  logic [pbfa_pkg::ValW-1:0]   mask;

  // sequencer
  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  logic                          type_q, type_d;
  logic [pbfa_pkg::IdxW-1:0]     idx_q, idx_d;
  logic [pbfa_pkg::ValW-1:0]     val_q, val_d;
  logic [pbfa_pkg::StartW-1:0]   start_q, start_d;
  logic                          oor_q, oor_d;
  logic                          trunc_q, trunc_d;
  logic [pbfa_pkg::ValW-1:0]     acc_q, acc_d;
  logic [pbfa_pkg::ItemWW-1:0]   k_q, k_d;
  logic [2:0]                    lo_q, lo_d;
  logic [AW-1:0]                 addr_q, addr_d;

  logic [pbfa_pkg::ValW-1:0]     rv_q, rv_d;
  logic                          ro_q, ro_d;
  logic                          rt_q, rt_d;

  // byte step datapath
  logic [pbfa_pkg::StartW-1:0]   end_bit;
  logic [3:0]                    avail;
  logic [pbfa_pkg::ItemWW-1:0]   rem;
  logic [3:0]                    n;
  logic [7:0]                    nmask8;
  logic [7:0]                    bmask;
  logic [7:0]                    chunk;
  logic [7:0]                    wbyte;
  logic [pbfa_pkg::ItemWW-1:0]   k_next;

  logic       ram_we;
  logic [7:0] ram_rdata;

  always_comb begin
    if (width_q == '0) begin
      w = 6'd1;
    end else if (width_q > 6'(pbfa_pkg::MaxWidth)) begin
      w = 6'(pbfa_pkg::MaxWidth);
    end else begin
      w = width_q;
    end
  end

  // repaired shift: width 32 shifts by zero
  assign mask = 32'hFFFF_FFFF >> (6'(pbfa_pkg::MaxWidth) - w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= pbfa_pkg::ItemWidthRst;
      cap_q   <= pbfa_pkg::CapacityRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pbfa_pkg::CfgItemWidth: width_q <= cfg_wdata_i[pbfa_pkg::ItemWW-1:0];
        pbfa_pkg::CfgCapacity:  cap_q   <= cfg_wdata_i[pbfa_pkg::CapW-1:0];
        default: ;
      endcase
    end
  end

  assign end_bit = start_q + pbfa_pkg::StartW'(w);
  assign avail   = 4'd8 - {1'b0, lo_q};
  assign rem     = w - k_q;
  assign n       = (pbfa_pkg::ItemWW'(avail) < rem) ? avail : rem[3:0];
  assign nmask8  = 8'hFF >> (4'd8 - n);
  assign bmask   = nmask8 << lo_q;
  assign chunk   = (ram_rdata >> lo_q) & nmask8;
  assign wbyte   = (ram_rdata & ~bmask) | ((val_q[7:0] << lo_q) & bmask);
  assign k_next  = k_q + {2'b00, n};

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    type_d      = type_q;
    idx_d       = idx_q;
    val_d       = val_q;
    start_d     = start_q;
    oor_d       = oor_q;
    trunc_d     = trunc_q;
    acc_d       = acc_q;
    k_d         = k_q;
    lo_d        = lo_q;
    addr_d      = addr_q;
    rv_d        = rv_q;
    ro_d        = ro_q;
    rt_d        = rt_q;
    ram_we      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          type_d  = req_type_i;
          idx_d   = item_index_i;
          val_d   = write_value_i;
          state_d = StCalc;
        end
      end
      StCalc: begin
        start_d = pbfa_pkg::StartW'(idx_q) * pbfa_pkg::StartW'(w);
        state_d = StChk;
      end
      StChk: begin
        oor_d   = ({1'b0, end_bit} > pbfa_pkg::CmpW'(cap_q)) || ({1'b0, end_bit} > MemBits);
        trunc_d = (type_q == pbfa_pkg::ReqWrite) && ((val_q & ~mask) != '0);
        val_d   = val_q & mask;
        acc_d   = '0;
        k_d     = '0;
        lo_d    = start_q[2:0];
        addr_d  = start_q[AW+2:3];
        state_d = oor_d ? StDone : StRd;
      end
      StRd: begin
        // RAM read issued at addr_q
        state_d = StMod;
      end
      StMod: begin
        if (type_q == pbfa_pkg::ReqWrite) begin
          ram_we = 1'b1;
        end else begin
          acc_d = acc_q | (pbfa_pkg::ValW'(chunk) << k_q[4:0]);
        end
        val_d   = val_q >> n;
        k_d     = k_next;
        lo_d    = '0;
        addr_d  = addr_q + AW'(1);
        state_d = (k_next >= w) ? StDone : StRd;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          rv_d        = acc_q;
          ro_d        = oor_q;
          rt_d        = trunc_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    idx_q   <= idx_d;
    val_q   <= val_d;
    start_q <= start_d;
    oor_q   <= oor_d;
    trunc_q <= trunc_d;
    acc_q   <= acc_d;
    k_q     <= k_d;
    lo_q    <= lo_d;
    addr_q  <= addr_d;
    rv_q    <= rv_d;
    ro_q    <= ro_d;
    rt_q    <= rt_d;
  end

  pbfa_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (addr_q),
    .wdata_i(wbyte),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign read_value_o   = rv_q;
  assign out_of_range_o = ro_q;
  assign truncated_o    = rt_q;

  // a dropped or read request never touches the store
  a_we_only_in_range_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!oor_q && type_q == pbfa_pkg::ReqWrite))
    else $error("ram write on read or out of range request");

  // the byte loop never runs past the item
  a_k_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMod) |-> (k_q < w))
    else $error("bit count past item width");

  // a read result carries no bits above the item width
  a_read_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((read_value_o & ~mask) == '0))
    else $error("read value has bits above item width");

  // truncated write and out of range responses return zero
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (truncated_o || out_of_range_o)) |-> (read_value_o == '0))
    else $error("nonzero value on write or out of range response");

endmodule
